### rtl/core/utf8cpd_pkg.sv
// Shared types, constants and lead-byte helpers for the UTF-8 code point decoder.
`timescale 1ns / 1ps

package utf8cpd_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CP_W   = 32;
   localparam int unsigned REM_W  = 3;

   localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
   localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;
   localparam logic [BYTE_W-1:0] SIX_BITS  = 8'h3F;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            end_of_string;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } dec_out_type;

   typedef struct packed {
      logic            valid;
      logic [BYTE_W-1:0] data_byte;
   } in_stage_type;

   // continuation bytes still expected after a lead byte (leading ones minus one)
   function automatic logic [REM_W-1:0] lead_remaining(input logic [BYTE_W-1:0] b);
      logic [REM_W-1:0] r;
      priority if (!b[5]) begin
         r = 3'd1;
      end else if (!b[4]) begin
         r = 3'd2;
      end else if (!b[3]) begin
         r = 3'd3;
      end else if (!b[2]) begin
         r = 3'd4;
      end else if (!b[1]) begin
         r = 3'd5;
      end else if (!b[0]) begin
         r = 3'd6;
      end else begin
         r = 3'd7;
      end
      return r;
   endfunction

   // payload bits of a lead byte; the eight-ones lead keeps the whole byte
   function automatic logic [CP_W-1:0] lead_payload(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] mask;
      unique case (lead_remaining(b))
         3'd1:    mask = 8'h1F;
         3'd2:    mask = 8'h0F;
         3'd3:    mask = 8'h07;
         3'd4:    mask = 8'h03;
         3'd5:    mask = 8'h01;
         3'd6:    mask = 8'h00;
         3'd7:    mask = 8'hFF;
         default: mask = 8'h00;
      endcase
      return {{(CP_W-BYTE_W){1'b0}}, b & mask};
   endfunction

endpackage

### rtl/core/utf8cpd_ifs.sv
// Valid/ready channel interfaces for string bytes and decoded code points.
`timescale 1ns / 1ps

interface utf8cpd_req_if;
   logic                         valid;
   logic                         ready;
   logic [utf8cpd_pkg::BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface utf8cpd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [utf8cpd_pkg::CP_W-1:0] code_point;
   logic                       end_of_string;

   modport source (output valid, output code_point, output end_of_string, input ready);
   modport sink   (input valid, input code_point, input end_of_string, output ready);
endinterface

### rtl/core/utf8cpd_in_reg.sv
// Input register stage holding one string byte until the decoder takes it.
`timescale 1ns / 1ps

module utf8cpd_in_reg (
   input  logic                      clock,
   input  logic                      reset,
   utf8cpd_req_if.sink               req_ch,
   input  logic                      take,
   output utf8cpd_pkg::in_stage_type stage
);

   logic                             valid_ff, valid_in;
   logic [utf8cpd_pkg::BYTE_W-1:0]   byte_ff, byte_in;
   logic                             load;

   assign req_ch.ready = !valid_ff || take;
   assign load         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = req_ch.data_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign stage.valid     = valid_ff;
   assign stage.data_byte = byte_ff;

endmodule

### rtl/core/utf8cpd_decode.sv
// Decoder state and single-pass decode of one byte into up to two results.
`timescale 1ns / 1ps

module utf8cpd_decode (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           fire,
   input  logic [utf8cpd_pkg::BYTE_W-1:0] data_byte,
   output utf8cpd_pkg::dec_out_type       dec_out
);

   logic [utf8cpd_pkg::CP_W-1:0]  acc_ff, acc_in;
   logic [utf8cpd_pkg::REM_W-1:0] rem_ff, rem_in;
   logic [utf8cpd_pkg::CP_W-1:0]  acc_shift;
   logic                          is_cont;
   logic                          st_valid;
   utf8cpd_pkg::result_type       st_res;

   assign is_cont   = (data_byte & utf8cpd_pkg::CONT_MASK) == utf8cpd_pkg::CONT_TAG;
   assign acc_shift = {acc_ff[utf8cpd_pkg::CP_W-7:0],
                       data_byte[5:0] & utf8cpd_pkg::SIX_BITS[5:0]};

   always_comb begin
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      dec_out  = '0;
      st_valid = 1'b0;
      st_res   = '0;
      if (rem_ff != '0 && is_cont) begin
         acc_in = acc_shift;
         rem_in = rem_ff - 3'd1;
         if (rem_ff == 3'd1) begin
            dec_out.count            = 2'd1;
            dec_out.first.code_point = acc_shift;
         end
      end else begin
         acc_in = '0;
         rem_in = '0;
         priority if (data_byte == '0) begin
            st_valid             = 1'b1;
            st_res.end_of_string = 1'b1;
         end else if (!data_byte[7]) begin
            st_valid          = 1'b1;
            st_res.code_point = {{(utf8cpd_pkg::CP_W-utf8cpd_pkg::BYTE_W){1'b0}}, data_byte};
         end else if (is_cont) begin
            st_valid = 1'b0;
         end else begin
            acc_in = utf8cpd_pkg::lead_payload(data_byte);
            rem_in = utf8cpd_pkg::lead_remaining(data_byte);
         end
         if (rem_ff != '0) begin
            dec_out.count = st_valid ? 2'd2 : 2'd1;
            dec_out.first = '0;
            if (st_valid) begin
               dec_out.second = st_res;
            end
         end else if (st_valid) begin
            dec_out.count = 2'd1;
            dec_out.first = st_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         rem_ff <= '0;
      end else if (fire) begin
         acc_ff <= acc_in;
         rem_ff <= rem_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_cont_advances: assert property (@(posedge clock) disable iff (reset)
      fire && rem_ff != '0 && is_cont |=> rem_ff == $past(rem_ff) - 3'd1)
      else $error("continuation did not advance the sequence");
   a_end_goes_idle: assert property (@(posedge clock) disable iff (reset)
      fire && data_byte == '0 |=> rem_ff == '0)
      else $error("terminator left a sequence open");
`endif

endmodule

### rtl/core/utf8cpd_out_buf.sv
// Result register with a spill register for the second result of a request.
`timescale 1ns / 1ps

module utf8cpd_out_buf (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  utf8cpd_pkg::dec_out_type dec_out,
   output logic                     can_take,
   utf8cpd_rsp_if.source            rsp_ch
);

   logic                    out_valid_ff, out_valid_in;
   logic                    spill_valid_ff, spill_valid_in;
   utf8cpd_pkg::result_type out_ff, out_in;
   utf8cpd_pkg::result_type spill_ff, spill_in;
   logic                    taken;

   assign taken    = out_valid_ff && rsp_ch.ready;
   assign can_take = !spill_valid_ff && (!out_valid_ff || rsp_ch.ready);

   always_comb begin
      out_valid_in   = out_valid_ff;
      spill_valid_in = spill_valid_ff;
      out_in         = out_ff;
      spill_in       = spill_ff;
      if (spill_valid_ff && taken) begin
         out_in         = spill_ff;
         spill_valid_in = 1'b0;
      end else if (fire) begin
         if (dec_out.count != 2'd0) begin
            out_valid_in = 1'b1;
            out_in       = dec_out.first;
         end else begin
            out_valid_in = 1'b0;
         end
         if (dec_out.count == 2'd2) begin
            spill_valid_in = 1'b1;
            spill_in       = dec_out.second;
         end
      end else if (taken) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         spill_valid_ff <= 1'b0;
      end else begin
         out_valid_ff   <= out_valid_in;
         spill_valid_ff <= spill_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff   <= out_in;
      spill_ff <= spill_in;
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.code_point    = out_ff.code_point;
   assign rsp_ch.end_of_string = out_ff.end_of_string;

`ifndef NO_ASSERTIONS
   a_spill_behind_out: assert property (@(posedge clock) disable iff (reset)
      spill_valid_ff |-> out_valid_ff)
      else $error("spill register holds a result ahead of the output");
   a_no_fire_on_spill: assert property (@(posedge clock) disable iff (reset)
      spill_valid_ff |-> !fire)
      else $error("decoder fired while the spill register was full");
   a_pair_spills: assert property (@(posedge clock) disable iff (reset)
      fire && dec_out.count == 2'd2 |=> spill_valid_ff && out_valid_ff)
      else $error("second result of a request was lost");
`endif

endmodule

### rtl/core/utf8_code_point_decoder.sv
// Top level of the streaming UTF-8 code point decoder.
//
//   channel  dir  payload                         handshake
//   req_ch   in   data_byte[7:0]                  valid/ready
//   rsp_ch   out  code_point[31:0], end_of_string valid/ready
//
// One byte per cycle while the result side takes results: a request enters the
// input register, is decoded in one pass and is written into the result register.
// A request that yields two results (broken sequence before an ASCII byte or
// terminator) holds the decoder while the spill register drains.
// Reset clears the sequence state and the input, result and spill valid flags.
// A stalled result side fills the result and input registers (and the spill
// register after a two-result request), then drops req_ch.ready.
`timescale 1ns / 1ps

module utf8_code_point_decoder (
   input  logic          clock,
   input  logic          reset,
   utf8cpd_req_if.sink   req_ch,
   utf8cpd_rsp_if.source rsp_ch
);

   utf8cpd_pkg::in_stage_type stage;
   utf8cpd_pkg::dec_out_type  dec_out;
   logic                      can_take;
   logic                      fire;

   assign fire = stage.valid && can_take;

   utf8cpd_in_reg u_in_reg (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .take   (fire),
      .stage  (stage)
   );

   utf8cpd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .data_byte (stage.data_byte),
      .dec_out   (dec_out)
   );

   utf8cpd_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .dec_out  (dec_out),
      .can_take (can_take),
      .rsp_ch   (rsp_ch)
   );

endmodule
